// ----- src/distinct_subsequence_counter_unit_defines.svh -----
// assertion macros for the distinct subsequence counter
`ifndef DISTINCT_SUBSEQUENCE_COUNTER_UNIT_DEFINES_SVH
`define DISTINCT_SUBSEQUENCE_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/dsc_pkg.sv -----
package dsc_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned LenW       = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LEN  = 2'd0,
    CFG_PATTERN_LOW  = 2'd1,
    CFG_PATTERN_HIGH = 2'd2
  } dsc_cfg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
  } in_word_t;

  typedef struct packed {
    logic [31:0] match_count;
    logic        overflowed;
  } out_word_t;

  typedef struct packed {
    logic [MaxPattern-1:0][7:0] pat_bytes;
    logic [IdxW-1:0]            last_idx;
  } pattern_cfg_t;

  typedef logic [CountWidth-1:0] count_t;

endpackage

// ----- src/dsc_cfg_regs.sv -----
module dsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output dsc_pkg::pattern_cfg_t         cfg_o
);
  import dsc_pkg::*;

  logic [LenW-1:0]     len_q;
  logic [CfgDataW-1:0] pat_low_q;
  logic [CfgDataW-1:0] pat_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LenW'(1);
      pat_low_q  <= '0;
      pat_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LEN:  len_q      <= cfg_wdata_i[LenW-1:0];
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_wdata_i;
        CFG_PATTERN_HIGH: pat_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp length into 1..MaxPattern, index of the last prefix entry
  always_comb begin
    if (len_q == '0) begin
      cfg_o.last_idx = '0;
    end else if (len_q > LenW'(MaxPattern)) begin
      cfg_o.last_idx = IdxW'(MaxPattern - 1);
    end else begin
      cfg_o.last_idx = IdxW'(len_q - LenW'(1));
    end
    for (int k = 0; k < MaxPattern; k++) begin
      if (k < 8) begin
        cfg_o.pat_bytes[k] = pat_low_q[8*k +: 8];
      end else begin
        cfg_o.pat_bytes[k] = pat_high_q[8*(k-8) +: 8];
      end
    end
  end

endmodule

// ----- src/dsc_prefix_array.sv -----
module dsc_prefix_array (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  dsc_pkg::in_word_t     in_word_i,
  input  dsc_pkg::pattern_cfg_t cfg_i,
  output dsc_pkg::out_word_t    result_o,
  output logic                  ovf_seen_o
);
  import dsc_pkg::*;

  count_t                           cnt_q [MaxPattern];
  count_t                           cnt_d [MaxPattern];
  count_t                           cur   [MaxPattern];
  count_t                           below [MaxPattern];
  logic   [MaxPattern-1:0]          sat;
  logic   [CountWidth:0]            sum   [MaxPattern];
  logic                             ovf_q;
  logic                             ovf_d;

  // start of text clears the old counts before this byte
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      cur[j] = in_word_i.start_of_text ? '0 : cnt_q[j];
    end
    below[0] = CountWidth'(1);
    for (int j = 1; j < MaxPattern; j++) begin
      below[j] = cur[j-1];
    end
  end

  // every matching prefix adds the old count of the prefix below, saturating
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      sum[j]   = {1'b0, cur[j]} + {1'b0, below[j]};
      sat[j]   = 1'b0;
      cnt_d[j] = cur[j];
      if ((IdxW'(j) <= cfg_i.last_idx) && (cfg_i.pat_bytes[j] == in_word_i.text_byte)) begin
        if (sum[j][CountWidth]) begin
          cnt_d[j] = '1;
          sat[j]   = 1'b1;
        end else begin
          cnt_d[j] = sum[j][CountWidth-1:0];
        end
      end
    end
  end

  assign ovf_d = (ovf_q && !in_word_i.start_of_text) || (|sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MaxPattern; j++) begin
        cnt_q[j] <= '0;
      end
      ovf_q <= 1'b0;
    end else if (advance_i) begin
      for (int j = 0; j < MaxPattern; j++) begin
        cnt_q[j] <= cnt_d[j];
      end
      ovf_q <= ovf_d;
    end
  end

  assign result_o.match_count = 32'(cnt_d[cfg_i.last_idx]);
  assign result_o.overflowed  = ovf_d;
  assign ovf_seen_o           = ovf_q;

endmodule

// ----- src/distinct_subsequence_counter_unit.sv -----
// distinct subsequence counter: an accepted word goes to the input register,
// then to the result register once that is empty or being drained; one word
// per cycle while out_ready_i stays high, set by one compare-add pass per prefix
// async active-low reset clears the prefix counts, overflow flag, pipeline valids
// and sets pattern_len to 1 with an all-zero pattern
`include "distinct_subsequence_counter_unit_defines.svh"

module distinct_subsequence_counter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [dsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // text words in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dsc_pkg::in_word_t             in_word_i,
  // count words out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dsc_pkg::out_word_t            out_word_o
);
  import dsc_pkg::*;

  pattern_cfg_t cfg;
  in_word_t     in_word_q;
  logic         in_valid_q;
  out_word_t    out_word_q;
  logic         out_valid_q;
  out_word_t    result;
  logic         ovf_seen;
  logic         advance;

  // pattern length and bytes, held in flops
  dsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the input register's word moves to the result register when the result
  // register is empty or is being drained in this same cycle
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  // input register takes a new word whenever its current one moves on
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
  end

  // prefix count state, updated once per word from the old counts
  dsc_prefix_array u_prefix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .in_word_i  (in_word_q),
    .cfg_i      (cfg),
    .result_o   (result),
    .ovf_seen_o (ovf_seen)
  );

  // result register separates the two handshakes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // every word that moves on shows up as a result
  `DSC_ASSERT_NXT(a_adv_gives_result, advance, out_valid_o, "result word missing after advance")
  // a blocked input word stays put
  `DSC_ASSERT_NXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_word_q),
    "input register lost a blocked word")
  // a new text can never report overflow on its first byte
  `DSC_ASSERT_NXT(a_start_clears_ovf, advance && in_word_q.start_of_text,
    !out_word_o.overflowed, "overflow flag survived start of text")
  // overflow is sticky within a text
  `DSC_ASSERT_NXT(a_ovf_sticky, advance && !in_word_q.start_of_text && ovf_seen,
    out_word_o.overflowed, "overflow flag dropped mid text")

endmodule

// ----- dv/subseq_count_checker.sv -----
`timescale 1ns / 1ps

module subseq_count_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  dsc_pkg::in_word_t            in_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  dsc_pkg::out_word_t           out_word_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import dsc_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // shadow of the pattern registers and the prefix counts
  logic [LenW-1:0] pat_len_q;
  logic [63:0]     pat_lo_q;
  logic [63:0]     pat_hi_q;
  count_t          prefix_cnt_q [MaxPattern];
  logic            sat_seen_q;

  out_word_t   count_fifo [$];
  out_word_t   want_w;
  int unsigned fails;

  // one text byte through the prefix count update, returns the count word
  function automatic out_word_t advance_counts(in_word_t w);
    int unsigned         len;
    logic [127:0]        pat;
    logic [CountWidth:0] sum;
    count_t              below;
    out_word_t           r;
    len = pat_len_q;
    if (len < 1) len = 1;
    if (len > MaxPattern) len = MaxPattern;
    pat = {pat_hi_q, pat_lo_q};
    if (w.start_of_text) begin
      for (int k = 0; k < MaxPattern; k++) prefix_cnt_q[k] = '0;
      sat_seen_q = 1'b0;
    end
    // top prefix first so each one adds the old count below it
    for (int j = len; j >= 1; j--) begin
      if (pat[8*(j-1) +: 8] == w.text_byte) begin
        if (j == 1) below = count_t'(1);
        else below = prefix_cnt_q[j-2];
        sum = {1'b0, prefix_cnt_q[j-1]} + {1'b0, below};
        if (sum[CountWidth]) begin
          prefix_cnt_q[j-1] = '1;
          sat_seen_q = 1'b1;
        end else begin
          prefix_cnt_q[j-1] = sum[CountWidth-1:0];
        end
      end
    end
    r.match_count = prefix_cnt_q[len-1][31:0];
    r.overflowed  = sat_seen_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  = LenW'(1);
      pat_lo_q   = '0;
      pat_hi_q   = '0;
      for (int k = 0; k < MaxPattern; k++) prefix_cnt_q[k] = '0;
      sat_seen_q = 1'b0;
      count_fifo.delete();
      fails      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LEN:  pat_len_q = cfg_wdata_i[LenW-1:0];
          CFG_PATTERN_LOW:  pat_lo_q  = cfg_wdata_i;
          CFG_PATTERN_HIGH: pat_hi_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) count_fifo.push_back(advance_counts(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (count_fifo.size() == 0) begin
          if (fails < ReportLimit)
            $display("%t: unexpected count word: count %0d overflowed %0b", $realtime,
                     out_word_i.match_count, out_word_i.overflowed);
          fails++;
        end else begin
          want_w = count_fifo.pop_front();
          if (want_w.match_count != out_word_i.match_count ||
              want_w.overflowed != out_word_i.overflowed) begin
            if (fails < ReportLimit)
              $display("%t: count word mismatch: expected %0d/%0b, got %0d/%0b", $realtime,
                       want_w.match_count, want_w.overflowed,
                       out_word_i.match_count, out_word_i.overflowed);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= count_fifo.size();
    end
  end

endmodule

// ----- dv/tb_distinct_subsequence_counter_unit.sv -----
`timescale 1ns / 1ps

module tb_distinct_subsequence_counter_unit;
  import dsc_pkg::*;

  // item budget and timing knobs
  localparam int unsigned TotalItems  = 1925;  // directed part plus random part
  localparam int unsigned CalmStart   = 1700;  // no idling on either side from here
  localparam int unsigned LongHold    = 64;    // receiver hold-off, long enough to fill the block
  localparam int unsigned DrainCycles = 8;     // margin after the last count word has come back
  localparam int unsigned IdleLimit   = 2000;  // watchdog: cycles with no handshake or register write

  // how a random phase builds its pattern
  typedef enum int unsigned {
    PAT_UNIFORM,  // one byte repeated, fastest route to saturation
    PAT_PAIR,     // two symbols
    PAT_RANDOM,   // every bit random, any length code
    PAT_EDGE,     // length 1 or 16, symbols include 0x00 and 0xff
    PAT_SHORT     // length 2..5, two symbols
  } pat_style_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_word;
  int unsigned         fail_count;
  int unsigned         pending;

  // stimulus side copy of the pattern, used to pick text bytes that hit
  logic [7:0]  pat_bytes [MaxPattern];
  int unsigned act_len;
  int unsigned sent;
  int unsigned idle_pct;
  bit          calm;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  distinct_subsequence_counter_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  // predicts and compares every count word, reports failures back here
  subseq_count_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off per request, steady in the calm part
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        // long stretch with ready low while the sender keeps offering words
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
        holds_done++;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // write all three pattern registers on back-to-back cycles, called only while idle
  task automatic load_pattern(input logic [LenW-1:0] len_w, input logic [63:0] lo,
                              input logic [63:0] hi);
    logic [63:0] len_word;
    int unsigned n;
    // bits above the length field are junk half of the time, the block keeps 5 bits
    len_word = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : 64'd0;
    len_word[LenW-1:0] = len_w;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PATTERN_LEN;
    cfg_wdata <= len_word;
    @(negedge clk);
    cfg_idx   <= CFG_PATTERN_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_idx   <= CFG_PATTERN_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      pat_bytes[k]     = lo[8*k +: 8];
      pat_bytes[k + 8] = hi[8*k +: 8];
    end
    // length zero acts as one, anything above the maximum as the maximum
    n = len_w;
    if (n < 1) n = 1;
    if (n > MaxPattern) n = MaxPattern;
    act_len = n;
  endtask

  // stop sending and wait until every count word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // offer one text word, with a random gap first, and wait for the handshake
  task automatic send_text_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {b, s};  // text_byte above start_of_text
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // mostly bytes of the active pattern so counts grow, the rest noise
  function automatic logic [7:0] text_pick(input int unsigned noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
    return pat_bytes[$urandom_range(0, act_len - 1)];
  endfunction

  // one text: start flag on its first byte unless it continues the old counts,
  // and now and then a stray start in the middle
  task automatic send_text(input int unsigned n, input bit fresh, input int unsigned noise_pct);
    logic s;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) s = fresh;
      else s = ($urandom_range(0, 99) < 2);
      send_text_byte(text_pick(noise_pct), s);
    end
  endtask

  // pick and load a pattern for a random phase
  task automatic random_pattern(input pat_style_e style);
    logic [7:0]      sym [3];
    logic [7:0]      pb [MaxPattern];
    logic [127:0]    packed_w;
    logic [LenW-1:0] len_w;
    for (int k = 0; k < 3; k++) sym[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < MaxPattern; k++) pb[k] = sym[$urandom_range(0, 1)];
    len_w = LenW'($urandom_range(1, MaxPattern));
    case (style)
      PAT_UNIFORM: begin
        for (int k = 0; k < MaxPattern; k++) pb[k] = sym[0];
        len_w = LenW'($urandom_range(10, 31));
      end
      PAT_PAIR: ;
      PAT_RANDOM: begin
        for (int k = 0; k < MaxPattern; k++) pb[k] = 8'($urandom_range(0, 255));
        len_w = LenW'($urandom_range(0, 31));
      end
      PAT_EDGE: begin
        sym[0] = 8'h00;
        sym[1] = 8'hff;
        for (int k = 0; k < MaxPattern; k++) pb[k] = sym[$urandom_range(0, 2)];
        len_w = ($urandom_range(0, 1) != 0) ? LenW'(MaxPattern) : LenW'(1);
      end
      PAT_SHORT: len_w = LenW'($urandom_range(2, 5));
      default: ;
    endcase
    for (int k = 0; k < MaxPattern; k++) packed_w[8*k +: 8] = pb[k];
    load_pattern(len_w, packed_w[63:0], packed_w[127:64]);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned min_len;
    int unsigned noise;
    bit          first;
    bit          fresh;
    pat_style_e  style;

    // every input known from time zero
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PATTERN_LEN;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    calm      = 1'b0;
    idle_pct  = 0;
    hold_reqs = 0;
    sent      = 0;
    act_len   = 1;
    for (int k = 0; k < MaxPattern; k++) pat_bytes[k] = 8'h00;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset pattern is length 1 of byte 0x00
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h00, 1'b1);  // start in the middle of a text
    settle();

    // length code zero behaves as length one
    load_pattern(LenW'(0), 64'h0000_0000_0000_00ff, 64'd0);
    send_text_byte(8'hff, 1'b1);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h00, 1'b0);
    settle();

    // length code above the maximum, pattern 0x00, 0x11 .. 0xff, text equals the pattern
    load_pattern(LenW'(31), 64'h7766_5544_3322_1100, 64'hffee_ddcc_bbaa_9988);
    for (int k = 0; k < MaxPattern; k++) send_text_byte(8'(k * 17), (k == 0));
    settle();

    // pattern change in the middle of a text keeps the counts
    load_pattern(LenW'(2), 64'h0000_0000_0000_ff00, 64'd0);
    send_text_byte(8'hff, 1'b0);

    // random phases: new pattern each phase, texts mostly well formed
    phase = 0;
    while (sent < TotalItems) begin
      settle();
      // first phase saturates for sure: one byte repeated, long texts
      if (phase == 0) style = PAT_UNIFORM;
      else style = pat_style_e'($urandom_range(0, 4));
      random_pattern(style);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (sent >= CalmStart) calm = 1'b1;
      if ((phase == 1 || phase == 6) && !calm) hold_reqs++;
      min_len   = (phase == 0) ? 36 : 1;
      noise     = (style == PAT_RANDOM) ? 40 : 10;
      phase_end = sent + $urandom_range(100, 200);
      first     = 1'b1;
      while (sent < phase_end && sent < TotalItems) begin
        // first text of a phase sometimes carries on with the old counts
        fresh = first ? ($urandom_range(0, 2) != 0) : 1'b1;
        send_text($urandom_range(min_len, 80), fresh, noise);
        // sender pause until the block has drained
        if (phase == 3 && first) settle();
        first = 1'b0;
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/dsc_pkg.sv
src/dsc_cfg_regs.sv
src/dsc_prefix_array.sv
src/distinct_subsequence_counter_unit.sv
dv/subseq_count_checker.sv
dv/tb_distinct_subsequence_counter_unit.sv
